// ----- rtl/sfs_pkg.sv -----
package sfs_pkg;

    // Strip size limit
    localparam int MAX_FRAMES = 256;

    // Field and register widths
    localparam int PERIOD_W  = 20;
    localparam int COUNT_W   = 9;
    localparam int WIDTH_W   = 13;
    localparam int MODE_W    = 2;
    localparam int OP_W      = 2;
    localparam int TIME_W    = 20;
    localparam int FRAME_W   = 8;
    localparam int OFFSET_W  = 20;
    localparam int ELAPSED_W = 21;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CYC_W     = COUNT_W + 1;
    localparam int PROD_W    = FRAME_W + WIDTH_W;

    // Shared divider sizing
    localparam int DIV_W     = 21;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd2;

    // Play modes
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd33333;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd1;
    localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_ONCE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TIME,
        ST_DIV_STEP,
        ST_UPDATE,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Clamp the frame count register into 1 .. MAX_FRAMES
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] n;
        n = count;
        if (count == '0)
        begin
            n = COUNT_W'(1);
        end
        else if (count > COUNT_W'(MAX_FRAMES))
        begin
            n = COUNT_W'(MAX_FRAMES);
        end
        return n;
    endfunction

endpackage

// ----- rtl/sprite_frame_sequencer_top.sv -----
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// in       | input     | in_valid/in_ready  | opcode, time_advance_us
// out      | output    | out_valid/out_ready| frame_index, strip_offset, reversed,
//          |           |                    | playing, ended
// cfg      | input     | cfg_wr_en          | cfg_addr, cfg_data
//
// Start, stop, no-op and advance while stopped go from accept straight to the result state.
// Advance while playing: a shift-subtract divide of elapsed time by the frame period,
// in loop and ping-pong a second one reducing the step count by the frame count (loop)
// or twice it (ping-pong), then an update state and the result state.
// One item at a time; in_ready is low from accept until the result is loaded. A result
// waiting on out_ready holds the sequencer in its last state; the next transaction is
// accepted as soon as the result is loaded. Reset initialises all but the result data.
module sprite_frame_sequencer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sfs_pkg::OP_W-1:0]        opcode,
    input  logic [sfs_pkg::TIME_W-1:0]      time_advance_us,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sfs_pkg::FRAME_W-1:0]     frame_index,
    output logic [sfs_pkg::OFFSET_W-1:0]    strip_offset,
    output logic                            reversed,
    output logic                            playing,
    output logic                            ended,
    input  logic                            cfg_wr_en,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sfs_pkg::CFG_W-1:0]       cfg_data
);

    // Configuration
    logic [sfs_pkg::PERIOD_W-1:0]  period_reg;
    logic [sfs_pkg::COUNT_W-1:0]   count_reg;
    logic [sfs_pkg::WIDTH_W-1:0]   width_reg;
    logic [sfs_pkg::MODE_W-1:0]    mode_reg;

    // Animation state
    logic [sfs_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [sfs_pkg::FRAME_W-1:0]   frame_reg;
    logic                          back_reg;
    logic                          run_reg;
    logic                          ended_reg;
    logic [sfs_pkg::DIV_W-1:0]     steps_reg;

    sfs_pkg::seq_state_t           state_reg;
    sfs_pkg::seq_state_t           state_next;

    // Result register
    logic                          out_valid_reg;
    logic [sfs_pkg::FRAME_W-1:0]   frame_index_reg;
    logic [sfs_pkg::OFFSET_W-1:0]  strip_offset_reg;
    logic                          reversed_reg;
    logic                          playing_reg;
    logic                          ended_out_reg;

    // Divider hookup
    logic                          div_start;
    logic [sfs_pkg::DIV_W-1:0]     div_dividend;
    logic [sfs_pkg::DIV_W-1:0]     div_divisor;
    sfs_pkg::div_status_t          div_stat;
    logic [sfs_pkg::DIV_W-1:0]     div_quotient;
    logic [sfs_pkg::DIV_W-1:0]     div_remainder;

    logic                          in_fire;
    logic                          load_out;
    logic                          mode_loop;
    logic                          mode_pp;

    logic [sfs_pkg::COUNT_W-1:0]   n_eff;
    logic [sfs_pkg::COUNT_W-1:0]   n_last;
    logic [sfs_pkg::CYC_W-1:0]     cyc;
    logic [sfs_pkg::PERIOD_W-1:0]  period_eff;
    logic [sfs_pkg::ELAPSED_W-1:0] total_time;
    logic [sfs_pkg::FRAME_W-1:0]   frame_clamped;

    logic [sfs_pkg::CYC_W-1:0]     rmd;
    logic [sfs_pkg::CYC_W-1:0]     loop_sum;
    logic [sfs_pkg::CYC_W-1:0]     loop_wrap;
    logic [sfs_pkg::CYC_W-1:0]     pp_start;
    logic [sfs_pkg::CYC_W:0]       pp_sum;
    logic [sfs_pkg::CYC_W:0]       pp_wrap;
    logic [sfs_pkg::CYC_W-1:0]     pp_pos;
    logic [sfs_pkg::CYC_W-1:0]     pp_mirror;
    logic                          pp_fwd;
    logic                          once_end;
    logic [sfs_pkg::FRAME_W-1:0]   once_frame;
    logic [sfs_pkg::PROD_W-1:0]    offset_prod;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == sfs_pkg::ST_IDLE);
    assign mode_loop = (mode_reg == sfs_pkg::MODE_LOOP);
    assign mode_pp   = (mode_reg == sfs_pkg::MODE_PINGPONG);

    // Effective register values
    assign n_eff      = sfs_pkg::eff_count(count_reg);
    assign n_last     = n_eff - sfs_pkg::COUNT_W'(1);
    assign cyc        = {n_eff, 1'b0};
    assign period_eff = (period_reg == '0) ? sfs_pkg::PERIOD_W'(1) : period_reg;
    assign total_time = elapsed_reg + sfs_pkg::ELAPSED_W'(time_advance_us);
    assign frame_clamped = ({1'b0, frame_reg} > n_last) ?
                           n_last[sfs_pkg::FRAME_W-1:0] : frame_reg;

    // Loop: move by steps mod n, wrap once
    assign rmd = div_remainder[sfs_pkg::CYC_W-1:0];
    always_comb
    begin
        if (back_reg)
        begin
            loop_sum = {2'b0, frame_reg} + {1'b0, n_eff} - rmd;
        end
        else
        begin
            loop_sum = {2'b0, frame_reg} + rmd;
        end
        loop_wrap = (loop_sum >= {1'b0, n_eff}) ? (loop_sum - {1'b0, n_eff}) : loop_sum;
    end

    // Ping-pong: position on the unfolded cycle of 2n, then fold back
    always_comb
    begin
        pp_start  = back_reg ? (cyc - sfs_pkg::CYC_W'(1) - {2'b0, frame_reg})
                             : {2'b0, frame_reg};
        pp_sum    = {1'b0, pp_start} + {1'b0, rmd};
        pp_wrap   = (pp_sum >= {1'b0, cyc}) ? (pp_sum - {1'b0, cyc}) : pp_sum;
        pp_pos    = pp_wrap[sfs_pkg::CYC_W-1:0];
        pp_fwd    = (pp_pos < {1'b0, n_eff});
        pp_mirror = cyc - sfs_pkg::CYC_W'(1) - pp_pos;
    end

    // Once: stop at either end of the strip
    always_comb
    begin
        if (back_reg)
        begin
            once_end   = (steps_reg > sfs_pkg::DIV_W'(frame_reg));
            once_frame = frame_reg - steps_reg[sfs_pkg::FRAME_W-1:0];
        end
        else
        begin
            once_end   = ({1'b0, steps_reg} + (sfs_pkg::DIV_W + 1)'(frame_reg))
                         >= (sfs_pkg::DIV_W + 1)'(n_eff);
            once_frame = frame_reg + steps_reg[sfs_pkg::FRAME_W-1:0];
        end
    end

    assign offset_prod = sfs_pkg::PROD_W'(frame_reg) * sfs_pkg::PROD_W'(width_reg);

    // Sequencer next state and divider control
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = total_time;
        div_divisor  = sfs_pkg::DIV_W'(period_eff);
        load_out     = 1'b0;
        case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((opcode == sfs_pkg::OP_ADVANCE) && run_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = sfs_pkg::ST_DIV_TIME;
                    end
                    else
                    begin
                        state_next = sfs_pkg::ST_RESULT;
                    end
                end
            end
            sfs_pkg::ST_DIV_TIME:
            begin
                div_dividend = div_quotient;
                div_divisor  = mode_loop ? sfs_pkg::DIV_W'(n_eff) : sfs_pkg::DIV_W'(cyc);
                if (div_stat.done)
                begin
                    if (mode_loop || mode_pp)
                    begin
                        div_start  = 1'b1;
                        state_next = sfs_pkg::ST_DIV_STEP;
                    end
                    else
                    begin
                        state_next = sfs_pkg::ST_UPDATE;
                    end
                end
            end
            sfs_pkg::ST_DIV_STEP:
            begin
                if (div_stat.done)
                begin
                    state_next = sfs_pkg::ST_UPDATE;
                end
            end
            sfs_pkg::ST_UPDATE:
            begin
                state_next = sfs_pkg::ST_RESULT;
            end
            sfs_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = sfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= sfs_pkg::PERIOD_RESET;
            count_reg  <= sfs_pkg::COUNT_RESET;
            width_reg  <= sfs_pkg::WIDTH_RESET;
            mode_reg   <= sfs_pkg::MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                sfs_pkg::REG_PERIOD: period_reg <= cfg_data[sfs_pkg::PERIOD_W-1:0];
                sfs_pkg::REG_COUNT:  count_reg  <= cfg_data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::REG_WIDTH:  width_reg  <= cfg_data[sfs_pkg::WIDTH_W-1:0];
                sfs_pkg::REG_MODE:   mode_reg   <= cfg_data[sfs_pkg::MODE_W-1:0];
                default:             mode_reg   <= mode_reg;
            endcase
        end
    end

    // Animation state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            frame_reg   <= '0;
            back_reg    <= 1'b0;
            run_reg     <= 1'b0;
            ended_reg   <= 1'b0;
            steps_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                sfs_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ended_reg <= 1'b0;
                        frame_reg <= frame_clamped;
                        case (opcode)
                            sfs_pkg::OP_START:
                            begin
                                frame_reg   <= '0;
                                back_reg    <= 1'b0;
                                elapsed_reg <= '0;
                                run_reg     <= 1'b1;
                            end
                            sfs_pkg::OP_STOP:
                            begin
                                run_reg <= 1'b0;
                            end
                            default:
                            begin
                                run_reg <= run_reg;
                            end
                        endcase
                    end
                end
                sfs_pkg::ST_DIV_TIME:
                begin
                    if (div_stat.done)
                    begin
                        steps_reg   <= div_quotient;
                        elapsed_reg <= div_remainder;
                    end
                end
                sfs_pkg::ST_UPDATE:
                begin
                    if (mode_loop)
                    begin
                        frame_reg <= loop_wrap[sfs_pkg::FRAME_W-1:0];
                    end
                    else if (mode_pp)
                    begin
                        frame_reg <= pp_fwd ? pp_pos[sfs_pkg::FRAME_W-1:0]
                                            : pp_mirror[sfs_pkg::FRAME_W-1:0];
                        back_reg  <= !pp_fwd;
                    end
                    else if (once_end)
                    begin
                        frame_reg   <= back_reg ? '0 : n_last[sfs_pkg::FRAME_W-1:0];
                        run_reg     <= 1'b0;
                        elapsed_reg <= '0;
                        ended_reg   <= 1'b1;
                    end
                    else
                    begin
                        frame_reg <= once_frame;
                    end
                end
                default:
                begin
                    steps_reg <= steps_reg;
                end
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            frame_index_reg  <= frame_reg;
            strip_offset_reg <= offset_prod[sfs_pkg::OFFSET_W-1:0];
            reversed_reg     <= back_reg;
            playing_reg      <= run_reg;
            ended_out_reg    <= ended_reg;
        end
    end

    sfs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign out_valid    = out_valid_reg;
    assign frame_index  = frame_index_reg;
    assign strip_offset = strip_offset_reg;
    assign reversed     = reversed_reg;
    assign playing      = playing_reg;
    assign ended        = ended_out_reg;

    // Divider work never overlaps an open input slot
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !in_ready)
        else $error("divider busy while input is ready");

    // A finished play-once strip is no longer playing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ended) |-> !playing)
        else $error("ended reported while still playing");

    // Reported frame lies inside the strip
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, frame_index} <= n_last))
        else $error("frame index beyond strip");

    // An accepted transaction leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != sfs_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accept");

endmodule

// ----- rtl/sfs_div.sv -----
module sfs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sfs_pkg::DIV_W-1:0]  dividend,
    input  logic [sfs_pkg::DIV_W-1:0]  divisor,
    output sfs_pkg::div_status_t       status,
    output logic [sfs_pkg::DIV_W-1:0]  quotient,
    output logic [sfs_pkg::DIV_W-1:0]  remainder
);

    logic [sfs_pkg::DIV_W-1:0]     quo_reg;
    logic [sfs_pkg::DIV_W:0]       rem_reg;
    logic [sfs_pkg::DIV_W-1:0]     dvs_reg;
    logic [sfs_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [sfs_pkg::DIV_W:0]       rem_shift;
    logic [sfs_pkg::DIV_W:0]       dvs_ext;
    logic                          fits;
    logic [sfs_pkg::DIV_W:0]       rem_next;
    logic [sfs_pkg::DIV_W-1:0]     quo_next;

    // One restoring step: shift in the next dividend bit, trial subtract
    always_comb
    begin
        rem_shift = {rem_reg[sfs_pkg::DIV_W-1:0], quo_reg[sfs_pkg::DIV_W-1]};
        dvs_ext   = {1'b0, dvs_reg};
        fits      = (rem_shift >= dvs_ext);
        rem_next  = fits ? (rem_shift - dvs_ext) : rem_shift;
        quo_next  = {quo_reg[sfs_pkg::DIV_W-2:0], fits};
    end

    // Sequence the bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - sfs_pkg::DIV_CNT_W'(1);
                if (cnt_reg == sfs_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then advance one quotient bit per cycle while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg[sfs_pkg::DIV_W-1:0];

endmodule
